@@ rtl/reaction_diffusion_point_update_macros.svh @@
// Assertion macros used by the point update port checker.
`ifndef REACTION_DIFFUSION_POINT_UPDATE_MACROS_SVH
`define REACTION_DIFFUSION_POINT_UPDATE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RDPU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define RDPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// What must hold in the cycle after a reset edge.
`define RDPU_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

@@ rtl/rdpu_pkg.sv @@
// Types, constants and saturating fixed-point helpers for the point update pipeline.
package rdpu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int UREG_BITS = 31;
  localparam int DATA_BITS = 32;
  localparam int IDX_BITS  = 3;
  localparam int N_STAGES  = 27;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic [IDX_BITS-1:0]         reg_idx_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

  // Q8.24 constants
  localparam word_t C_THIRD = word_t'(5592405);
  localparam word_t C_HALF  = word_t'(8388608);
  localparam word_t C_SIXTH = word_t'(2796203);

  localparam prod_t ROUND_HALF = prod_t'(1) << (FRAC_BITS - 1);

  // register map
  localparam reg_idx_t REG_TIME_STEP     = 3'd0;
  localparam reg_idx_t REG_EPS_VALUE     = 3'd1;
  localparam reg_idx_t REG_INV_EPS       = 3'd2;
  localparam reg_idx_t REG_BETA_VALUE    = 3'd3;
  localparam reg_idx_t REG_GAMMA_VALUE   = 3'd4;
  localparam reg_idx_t REG_INV_H_SQUARED = 3'd5;
  localparam reg_idx_t REG_USE_RK4       = 3'd6;
  localparam reg_idx_t REG_RK_STAGE      = 3'd7;

  // RK4 stage codes
  localparam logic [1:0] RK_STAGE_0 = 2'd0;
  localparam logic [1:0] RK_STAGE_1 = 2'd1;
  localparam logic [1:0] RK_STAGE_2 = 2'd2;
  localparam logic [1:0] RK_STAGE_3 = 2'd3;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } res_t;

  typedef struct packed {
    word_t      dt;
    word_t      eps;
    word_t      ieps;
    word_t      beta;
    word_t      gam;
    word_t      ihh;
    logic       rk;
    logic [1:0] st;
  } cfg_t;

  // Everything one point carries down the pipe; unused slots are pruned.
  typedef struct packed {
    logic  f;
    word_t u;
    word_t v;
    word_t xu;
    word_t xv;
    word_t su;
    word_t sv;
    word_t nx;
    word_t ny;
    word_t nz;
    word_t u2;
    word_t u4;
    word_t u6;
    word_t uu;
    word_t gv;
    word_t uuu;
    word_t lap;
    word_t d2u;
    word_t cube;
    word_t r;
    word_t ku;
    word_t kv;
    word_t tk;
    word_t k2;
    word_t t;
    word_t h;
    word_t un;
    word_t vn;
    word_t sku;
    word_t skv;
    prod_t p0;
    prod_t p1;
  } pipe_t;

  function automatic res_t sat_add(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    res_t               r;
    s     = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    r.ovf = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.val = r.ovf ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic res_t sat_sub(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    res_t               r;
    s     = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    r.ovf = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.val = r.ovf ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic prod_t mul_full(input word_t a, input word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // Drop the fraction bits, ties away from zero, then clip to a word.
  function automatic res_t rnd_prod(input prod_t p);
    prod_t                                 q;
    logic [PROD_BITS-WORD_BITS-FRAC_BITS:0] top;
    res_t                                  r;
    q     = p + ROUND_HALF - prod_t'(p[PROD_BITS-1]);
    top   = q[PROD_BITS-1:WORD_BITS+FRAC_BITS-1];
    r.ovf = !((&top) || !(|top));
    r.val = r.ovf ? (q[PROD_BITS-1] ? WORD_MIN : WORD_MAX)
                  : q[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
    return r;
  endfunction

endpackage

@@ rtl/reaction_diffusion_point_update.sv @@
// FitzHugh-Nagumo point update: 7-point Laplacian, reactions, Euler or RK4 stage.
//
// Input channel: point_valid / point_stall carry one grid point per transfer
// (u and its six neighbours, v, start-of-step values and the running slope sums).
// Output channel: result_valid / result_stall carry u_next, v_next, the updated
// slope sums and the saturated flag. A transfer happens on a rising edge with
// valid high and stall low.
// The datapath is a 27-stage register pipeline, one multiply or one saturating
// add/sub level per stage; the chain of dependent products (u^3, reaction,
// dt*k, stage weight, then the same again for v) sets that depth.
// Throughput: one point per cycle while result_stall is low.
// Each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up and points are still taken while a
// finished result waits at the output. If result_stall is held long enough
// the pipe fills and point_stall rises; nothing is lost or repeated, and the
// output payload stays put while stalled.
// Registers are written through write_enable / reg_index / write_data; the user must
// write them only while the pipe is empty; the block does not enforce it. Reset (rst,
// synchronous) empties the pipe and loads the default coefficients, in RK4 mode, stage 0.
module reaction_diffusion_point_update (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    write_enable,
  input  rdpu_pkg::reg_idx_t      reg_index,
  input  logic [31:0]             write_data,
  input  logic                    point_valid,
  output logic                    point_stall,
  input  logic signed [31:0]      u_center,
  input  logic signed [31:0]      u_x_plus,
  input  logic signed [31:0]      u_x_minus,
  input  logic signed [31:0]      u_y_plus,
  input  logic signed [31:0]      u_y_minus,
  input  logic signed [31:0]      u_z_plus,
  input  logic signed [31:0]      u_z_minus,
  input  logic signed [31:0]      v_center,
  input  logic signed [31:0]      u_start,
  input  logic signed [31:0]      v_start,
  input  logic signed [31:0]      sum_ku,
  input  logic signed [31:0]      sum_kv,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [31:0]      u_next,
  output logic signed [31:0]      v_next,
  output logic signed [31:0]      sum_ku_next,
  output logic signed [31:0]      sum_kv_next,
  output logic                    saturated
);

  localparam int N = rdpu_pkg::N_STAGES;

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  logic        [rdpu_pkg::UREG_BITS-1:0] time_step;
  logic        [rdpu_pkg::UREG_BITS-1:0] eps_value;
  logic        [rdpu_pkg::UREG_BITS-1:0] inv_eps;
  logic signed [rdpu_pkg::DATA_BITS-1:0] beta_value;
  logic signed [rdpu_pkg::DATA_BITS-1:0] gamma_value;
  logic        [rdpu_pkg::UREG_BITS-1:0] inv_h_squared;
  logic                                  use_rk4;
  logic        [1:0]                     rk_stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step     <= 31'd838861;
      eps_value     <= 31'd5033165;
      inv_eps       <= 31'd55924053;
      beta_value    <= 32'sd11744051;
      gamma_value   <= 32'sd8388608;
      inv_h_squared <= 31'd21123018;
      use_rk4       <= 1'b1;
      rk_stage      <= rdpu_pkg::RK_STAGE_0;
    end else if (write_enable) begin
      case (reg_index)
        rdpu_pkg::REG_TIME_STEP:     time_step     <= write_data[rdpu_pkg::UREG_BITS-1:0];
        rdpu_pkg::REG_EPS_VALUE:     eps_value     <= write_data[rdpu_pkg::UREG_BITS-1:0];
        rdpu_pkg::REG_INV_EPS:       inv_eps       <= write_data[rdpu_pkg::UREG_BITS-1:0];
        rdpu_pkg::REG_BETA_VALUE:    beta_value    <= write_data;
        rdpu_pkg::REG_GAMMA_VALUE:   gamma_value   <= write_data;
        rdpu_pkg::REG_INV_H_SQUARED: inv_h_squared <= write_data[rdpu_pkg::UREG_BITS-1:0];
        rdpu_pkg::REG_USE_RK4:       use_rk4       <= write_data[0];
        rdpu_pkg::REG_RK_STAGE:      rk_stage      <= write_data[1:0];
        default: ;
      endcase
    end
  end

  // The user must change registers only while the pipe is empty (the block does
  // not enforce it), so every stage reads them directly.
  rdpu_pkg::cfg_t cfg;

  always_comb begin
    cfg.dt   = rdpu_pkg::word_t'({1'b0, time_step});
    cfg.eps  = rdpu_pkg::word_t'({1'b0, eps_value});
    cfg.ieps = rdpu_pkg::word_t'({1'b0, inv_eps});
    cfg.beta = beta_value;
    cfg.gam  = gamma_value;
    cfg.ihh  = rdpu_pkg::word_t'({1'b0, inv_h_squared});
    cfg.rk   = use_rk4;
    cfg.st   = rk_stage;
  end

  // ---------------------------------------------------------------------------
  // Stage logic, stages 1 to 26. Stage 0 works straight off the ports below.
  // u side: Laplacian and reactions give ku, then the u update.
  // v side: kv from u (RK4) or from the new u (Euler), then the v update.
  // Both sides share one update shape: T = k or S + k, t = dt*T, h = w*t
  // (skipped for RK4 stage 2 and Euler), result = X + h.
  // ---------------------------------------------------------------------------
  function automatic rdpu_pkg::pipe_t stage_op(input int idx, input rdpu_pkg::pipe_t d,
                                               input rdpu_pkg::cfg_t c);
    rdpu_pkg::pipe_t q;
    rdpu_pkg::res_t  r0;
    rdpu_pkg::res_t  r1;
    rdpu_pkg::res_t  r2;
    rdpu_pkg::res_t  r3;
    logic            pre3;
    logic            mid;
    logic            use_c;
    rdpu_pkg::word_t cval;
    q     = d;
    r0    = '0;
    r1    = '0;
    r2    = '0;
    r3    = '0;
    pre3  = c.rk && (c.st == rdpu_pkg::RK_STAGE_3);
    mid   = c.rk && ((c.st == rdpu_pkg::RK_STAGE_1) || (c.st == rdpu_pkg::RK_STAGE_2));
    use_c = c.rk && (c.st != rdpu_pkg::RK_STAGE_2);
    cval  = (c.st == rdpu_pkg::RK_STAGE_3) ? rdpu_pkg::C_SIXTH : rdpu_pkg::C_HALF;
    case (idx)
      1: begin
        r0   = rdpu_pkg::sat_add(d.nx, d.ny);
        r1   = rdpu_pkg::sat_add(d.u2, d.u2);
        r2   = rdpu_pkg::rnd_prod(d.p0);
        r3   = rdpu_pkg::rnd_prod(d.p1);
        q.nx = r0.val;
        q.u4 = r1.val;
        q.uu = r2.val;
        q.gv = r3.val;
      end
      2: begin
        r0   = rdpu_pkg::sat_add(d.nx, d.nz);
        r1   = rdpu_pkg::sat_add(d.u4, d.u2);
        q.nx = r0.val;
        q.u6 = r1.val;
        q.p0 = rdpu_pkg::mul_full(d.uu, d.u);
      end
      3: begin
        r0    = rdpu_pkg::sat_sub(d.nx, d.u6);
        r1    = rdpu_pkg::rnd_prod(d.p0);
        q.lap = r0.val;
        q.uuu = r1.val;
      end
      4: begin
        q.p0 = rdpu_pkg::mul_full(d.lap, c.ihh);
        q.p1 = rdpu_pkg::mul_full(d.uuu, rdpu_pkg::C_THIRD);
      end
      5: begin
        r0     = rdpu_pkg::rnd_prod(d.p0);
        r1     = rdpu_pkg::rnd_prod(d.p1);
        q.d2u  = r0.val;
        q.cube = r1.val;
      end
      6: begin
        r0  = rdpu_pkg::sat_sub(d.u, d.cube);
        q.r = r0.val;
      end
      7: begin
        r0  = rdpu_pkg::sat_sub(d.r, d.v);
        q.r = r0.val;
      end
      8: q.p0 = rdpu_pkg::mul_full(d.r, c.ieps);
      9: begin
        r0  = rdpu_pkg::rnd_prod(d.p0);
        q.r = r0.val;
      end
      10: begin
        r0   = rdpu_pkg::sat_add(d.r, d.d2u);
        q.ku = r0.val;
      end
      11: begin
        if (pre3) begin
          r0   = rdpu_pkg::sat_add(d.su, d.ku);
          q.tk = r0.val;
        end else begin
          q.tk = d.ku;
        end
        if (mid) begin
          r1   = rdpu_pkg::sat_add(d.ku, d.ku);
          q.k2 = r1.val;
        end
      end
      12: begin
        q.p0 = rdpu_pkg::mul_full(c.dt, d.tk);
        if (!c.rk) begin
          q.sku = '0;
        end else if (c.st == rdpu_pkg::RK_STAGE_0) begin
          q.sku = d.ku;
        end else if (c.st == rdpu_pkg::RK_STAGE_3) begin
          q.sku = d.tk;
        end else begin
          r0    = rdpu_pkg::sat_add(d.su, d.k2);
          q.sku = r0.val;
        end
      end
      13: begin
        r0  = rdpu_pkg::rnd_prod(d.p0);
        q.t = r0.val;
      end
      14: q.p0 = rdpu_pkg::mul_full(cval, d.t);
      15: begin
        if (use_c) begin
          r0  = rdpu_pkg::rnd_prod(d.p0);
          q.h = r0.val;
        end else begin
          q.h = d.t;
        end
      end
      16: begin
        r0   = rdpu_pkg::sat_add(c.rk ? d.xu : d.u, d.h);
        q.un = r0.val;
      end
      17: begin
        r0  = rdpu_pkg::sat_add(c.rk ? d.u : d.un, c.beta);
        q.r = r0.val;
      end
      18: begin
        r0  = rdpu_pkg::sat_sub(d.r, d.gv);
        q.r = r0.val;
      end
      19: q.p0 = rdpu_pkg::mul_full(c.eps, d.r);
      20: begin
        r0   = rdpu_pkg::rnd_prod(d.p0);
        q.kv = r0.val;
      end
      21: begin
        if (pre3) begin
          r0   = rdpu_pkg::sat_add(d.sv, d.kv);
          q.tk = r0.val;
        end else begin
          q.tk = d.kv;
        end
        if (mid) begin
          r1   = rdpu_pkg::sat_add(d.kv, d.kv);
          q.k2 = r1.val;
        end
      end
      22: begin
        q.p0 = rdpu_pkg::mul_full(c.dt, d.tk);
        if (!c.rk) begin
          q.skv = '0;
        end else if (c.st == rdpu_pkg::RK_STAGE_0) begin
          q.skv = d.kv;
        end else if (c.st == rdpu_pkg::RK_STAGE_3) begin
          q.skv = d.tk;
        end else begin
          r0    = rdpu_pkg::sat_add(d.sv, d.k2);
          q.skv = r0.val;
        end
      end
      23: begin
        r0  = rdpu_pkg::rnd_prod(d.p0);
        q.t = r0.val;
      end
      24: q.p0 = rdpu_pkg::mul_full(cval, d.t);
      25: begin
        if (use_c) begin
          r0  = rdpu_pkg::rnd_prod(d.p0);
          q.h = r0.val;
        end else begin
          q.h = d.t;
        end
      end
      26: begin
        r0   = rdpu_pkg::sat_add(c.rk ? d.xv : d.v, d.h);
        q.vn = r0.val;
      end
      default: ;
    endcase
    q.f = d.f | r0.ovf | r1.ovf | r2.ovf | r3.ovf;
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 0: neighbour pair sums, 2u, u*u and gamma*v
  // ---------------------------------------------------------------------------
  rdpu_pkg::pipe_t head;
  rdpu_pkg::res_t  a0;
  rdpu_pkg::res_t  a1;
  rdpu_pkg::res_t  a2;
  rdpu_pkg::res_t  a3;

  always_comb begin
    a0      = rdpu_pkg::sat_add(u_x_plus, u_x_minus);
    a1      = rdpu_pkg::sat_add(u_y_plus, u_y_minus);
    a2      = rdpu_pkg::sat_add(u_z_plus, u_z_minus);
    a3      = rdpu_pkg::sat_add(u_center, u_center);
    head    = '0;
    head.u  = u_center;
    head.v  = v_center;
    head.xu = u_start;
    head.xv = v_start;
    head.su = sum_ku;
    head.sv = sum_kv;
    head.nx = a0.val;
    head.ny = a1.val;
    head.nz = a2.val;
    head.u2 = a3.val;
    head.p0 = rdpu_pkg::mul_full(u_center, u_center);
    head.p1 = rdpu_pkg::mul_full(cfg.gam, v_center);
    head.f  = a0.ovf | a1.ovf | a2.ovf | a3.ovf;
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers and flow control
  // ---------------------------------------------------------------------------
  rdpu_pkg::pipe_t pipe [N];
  rdpu_pkg::pipe_t nxt  [N];
  logic [N-1:0]    vld;
  logic [N-1:0]    vin;
  logic [N-1:0]    adv;

  assign vin = {vld[N-2:0], point_valid};

  // A stage moves when it is empty or its successor moves.
  for (genvar g = 0; g < N; g++) begin : g_stage
    if (g == N - 1) begin : g_last
      assign adv[g] = !vld[g] || !result_stall;
    end else begin : g_mid
      assign adv[g] = !vld[g] || adv[g+1];
    end
    if (g == 0) begin : g_head
      assign nxt[g] = head;
    end else begin : g_body
      assign nxt[g] = stage_op(g, pipe[g-1], cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (adv[i]) begin
          vld[i] <= vin[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (adv[i]) begin
        pipe[i] <= nxt[i];
      end
    end
  end

  assign point_stall  = !adv[0];
  assign result_valid = vld[N-1];
  assign u_next       = pipe[N-1].un;
  assign v_next       = pipe[N-1].vn;
  assign sum_ku_next  = pipe[N-1].sku;
  assign sum_kv_next  = pipe[N-1].skv;
  assign saturated    = pipe[N-1].f;

endmodule

@@ rtl/rdpu_checker.sv @@
// Port-level checks on the point update pipeline, bound to the top level.
`include "reaction_diffusion_point_update_macros.svh"

module rdpu_checker (
  input logic              clk,
  input logic              rst,
  input logic              point_valid,
  input logic              point_stall,
  input logic              result_valid,
  input logic              result_stall,
  input logic signed [31:0] u_next,
  input logic signed [31:0] v_next,
  input logic signed [31:0] sum_ku_next,
  input logic signed [31:0] sum_kv_next,
  input logic              saturated
);

  logic [128:0] result_word;

  assign result_word = {u_next, v_next, sum_ku_next, sum_kv_next, saturated};

  // a held result keeps its valid and its payload
  `RDPU_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_word), "result changed while stalled")

  // reset leaves an empty pipe that takes points at once
  `RDPU_ASSERT_RESET(a_reset_empty, !result_valid && !point_stall, "pipe not empty after reset")

  // back-pressure only when the output is full and stalled
  `RDPU_ASSERT_SAME(a_stall_cause, point_stall, result_valid && result_stall, "input stalled with output free")

  // with the output moving, the input never stalls
  `RDPU_ASSERT_SAME(a_flow_free, point_valid && !result_stall, !point_stall, "input stalled while output drains")

endmodule

bind reaction_diffusion_point_update rdpu_checker u_rdpu_checker (.*);

@@ sim/rdpu_update_check.sv @@
// Point update checker: mirrors the coefficients, predicts each result and compares it.
module rdpu_update_check
  import rdpu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     write_enable,
  input  reg_idx_t reg_index,
  input  logic [31:0] write_data,
  input  logic     point_valid,
  input  logic     point_stall,
  input  word_t    u_center,
  input  word_t    u_x_plus,
  input  word_t    u_x_minus,
  input  word_t    u_y_plus,
  input  word_t    u_y_minus,
  input  word_t    u_z_plus,
  input  word_t    u_z_minus,
  input  word_t    v_center,
  input  word_t    u_start,
  input  word_t    v_start,
  input  word_t    sum_ku,
  input  word_t    sum_kv,
  input  logic     result_valid,
  input  logic     result_stall,
  input  word_t    u_next,
  input  word_t    v_next,
  input  word_t    sum_ku_next,
  input  word_t    sum_kv_next,
  input  logic     saturated,
  output int       fail_count,
  output int       results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam word_t DT_RESET    = word_t'(838861);
  localparam word_t EPS_RESET   = word_t'(5033165);
  localparam word_t IEPS_RESET  = word_t'(55924053);
  localparam word_t BETA_RESET  = word_t'(11744051);
  localparam word_t GAMMA_RESET = word_t'(8388608);
  localparam word_t IHH_RESET   = word_t'(21123018);

  // far more than the pipe can hold in flight
  localparam int PEND_DEPTH = 64;

  typedef struct packed {
    word_t u, xp, xm, yp, ym, zp, zm, v, us, vs, sku, skv;
  } point_t;

  typedef struct packed {
    word_t un, vn, sku, skv;
    logic  sat;
  } update_t;

  cfg_t       coeffs;
  update_t    pending_updates [PEND_DEPTH];
  logic [5:0] pend_wr;
  logic [5:0] pend_rd;
  bit         clip_seen;

  // Operands are already word sized, so only intermediate results can clip.
  function automatic word_t fit_word(input longint x);
    if (x > longint'(WORD_MAX)) begin
      clip_seen = 1'b1;
      return WORD_MAX;
    end
    if (x < longint'(WORD_MIN)) begin
      clip_seen = 1'b1;
      return WORD_MIN;
    end
    return word_t'(x);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    return fit_word(longint'(a) + longint'(b));
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    return fit_word(longint'(a) - longint'(b));
  endfunction

  // Q8.24 product, magnitude rounded half up so ties go away from zero.
  function automatic word_t qmul(input word_t a, input word_t b);
    longint p;
    longint mag;
    p   = longint'(a) * longint'(b);
    mag = ((p < 0) ? -p : p) + (longint'(1) << (FRAC_BITS - 1));
    mag = mag >>> FRAC_BITS;
    return fit_word((p < 0) ? -mag : mag);
  endfunction

  function automatic update_t advance_point(input point_t p, input cfg_t c);
    update_t r;
    word_t   nsum, u2, u6, lap, d2u, cube, react, ku, kv, su, sv;
    clip_seen = 1'b0;
    r         = '0;
    nsum  = sadd(sadd(sadd(p.xp, p.xm), sadd(p.yp, p.ym)), sadd(p.zp, p.zm));
    u2    = sadd(p.u, p.u);
    u6    = sadd(sadd(u2, u2), u2);
    lap   = ssub(nsum, u6);
    d2u   = qmul(lap, c.ihh);
    cube  = qmul(qmul(qmul(p.u, p.u), p.u), C_THIRD);
    react = ssub(ssub(p.u, cube), p.v);
    ku    = sadd(qmul(react, c.ieps), d2u);
    if (!c.rk) begin
      // Euler: v slope uses the freshly stepped u
      r.un = sadd(p.u, qmul(c.dt, ku));
      kv   = qmul(c.eps, ssub(sadd(r.un, c.beta), qmul(c.gam, p.v)));
      r.vn = sadd(p.v, qmul(c.dt, kv));
    end else begin
      kv = qmul(c.eps, ssub(sadd(p.u, c.beta), qmul(c.gam, p.v)));
      case (c.st)
        RK_STAGE_0: begin
          r.un  = sadd(p.us, qmul(C_HALF, qmul(c.dt, ku)));
          r.vn  = sadd(p.vs, qmul(C_HALF, qmul(c.dt, kv)));
          r.sku = ku;
          r.skv = kv;
        end
        RK_STAGE_3: begin
          r.sku = sadd(p.sku, ku);
          r.skv = sadd(p.skv, kv);
          r.un  = sadd(p.us, qmul(C_SIXTH, qmul(c.dt, r.sku)));
          r.vn  = sadd(p.vs, qmul(C_SIXTH, qmul(c.dt, r.skv)));
        end
        default: begin
          su = qmul(c.dt, ku);
          sv = qmul(c.dt, kv);
          if (c.st == RK_STAGE_1) begin
            su = qmul(C_HALF, su);
            sv = qmul(C_HALF, sv);
          end
          r.un  = sadd(p.us, su);
          r.vn  = sadd(p.vs, sv);
          r.sku = sadd(p.sku, sadd(ku, ku));
          r.skv = sadd(p.skv, sadd(kv, kv));
        end
      endcase
    end
    r.sat = clip_seen;
    return r;
  endfunction

  function automatic int field_bad(input string name, input logic signed [32:0] want,
                                   input logic signed [32:0] got);
    if (got === want) return 0;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    point_t  pt;
    update_t want;
    int      bad;
    if (rst) begin
      coeffs = '{dt: DT_RESET, eps: EPS_RESET, ieps: IEPS_RESET, beta: BETA_RESET,
                 gam: GAMMA_RESET, ihh: IHH_RESET, rk: 1'b1, st: RK_STAGE_0};
      pend_wr = '0;
      pend_rd = '0;
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      if (write_enable) begin
        case (reg_index)
          REG_TIME_STEP:     coeffs.dt   = {1'b0, write_data[30:0]};
          REG_EPS_VALUE:     coeffs.eps  = {1'b0, write_data[30:0]};
          REG_INV_EPS:       coeffs.ieps = {1'b0, write_data[30:0]};
          REG_BETA_VALUE:    coeffs.beta = write_data;
          REG_GAMMA_VALUE:   coeffs.gam  = write_data;
          REG_INV_H_SQUARED: coeffs.ihh  = {1'b0, write_data[30:0]};
          REG_USE_RK4:       coeffs.rk   = write_data[0];
          REG_RK_STAGE:      coeffs.st   = write_data[1:0];
          default: ;
        endcase
      end
      if (point_valid && !point_stall) begin
        pt = '{u_center, u_x_plus, u_x_minus, u_y_plus, u_y_minus, u_z_plus, u_z_minus,
               v_center, u_start, v_start, sum_ku, sum_kv};
        pending_updates[pend_wr] = advance_point(pt, coeffs);
        pend_wr = pend_wr + 6'd1;
      end
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (pend_wr == pend_rd) begin
          $display("%0t: result transfer with nothing outstanding, u_next %0d", $time, u_next);
          fail_count <= fail_count + 1;
        end else begin
          want    = pending_updates[pend_rd];
          pend_rd = pend_rd + 6'd1;
          bad  = field_bad("u_next", want.un, u_next)
               + field_bad("v_next", want.vn, v_next)
               + field_bad("sum_ku_next", want.sku, sum_ku_next)
               + field_bad("sum_kv_next", want.skv, sum_kv_next)
               + field_bad("saturated", {32'b0, want.sat}, {32'b0, saturated});
          fail_count <= fail_count + bad;
        end
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Top-level bench for the point update block: stimulus, coefficient phases and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rdpu_pkg::*;

  // Generous ceiling; a correct run needs a small fraction of it.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 28;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    word_t u, xp, xm, yp, ym, zp, zm, v, us, vs, sku, skv;
  } point_in_t;

  typedef enum {PT_ZERO, PT_TOP, PT_BOTTOM, PT_SPLIT, PT_PLAIN, PT_WILD, PT_EDGE} point_kind_t;
  typedef enum {CF_TYPICAL, CF_WILD, CF_HIGH, CF_LOW} coeff_kind_t;
  typedef enum {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_t;

  logic        clk;
  logic        rst;
  logic        write_enable;
  reg_idx_t    reg_index;
  logic [31:0] write_data;
  logic        point_valid;
  logic        point_stall;
  word_t       u_center, u_x_plus, u_x_minus, u_y_plus, u_y_minus, u_z_plus, u_z_minus;
  word_t       v_center, u_start, v_start, sum_ku, sum_kv;
  logic        result_valid;
  logic        result_stall;
  word_t       u_next, v_next, sum_ku_next, sum_kv_next;
  logic        saturated;
  int          fail_count;
  int          results_seen;
  int          points_sent = 0;
  int          cycles = 0;

  reaction_diffusion_point_update u_top (.*);

  // Watches both channels and the write port; reports mismatches itself.
  rdpu_update_check u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver back-pressure: the mode is re-picked at random among no stalls, scattered
  // stalls, or long stall runs that back the pipe up into point_stall.
  initial begin
    stall_mode_t mode;
    int unsigned tick;
    mode = STALL_NONE;
    tick = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 128 == 0) mode = stall_mode_t'($urandom_range(0, 2));
      case (mode)
        STALL_NONE:   result_stall <= 1'b0;
        STALL_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
        default:      result_stall <= ((tick % 64) < 30);
      endcase
    end
  end

  // Random value within span of a centre; spans are kept well inside a word.
  function automatic word_t near(input word_t centre, input int span);
    return word_t'(longint'(centre) + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic word_t edge_value();
    case ($urandom_range(0, 5))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return word_t'(1);
      4:       return word_t'(-1);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic point_in_t make_point(input point_kind_t kind);
    point_in_t p;
    word_t     u, v;
    p = '0;
    case (kind)
      PT_ZERO:   p = '0;
      PT_TOP:    p = {12{WORD_MAX}};
      PT_BOTTOM: p = {12{WORD_MIN}};
      PT_SPLIT:  p = '{WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                       WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN};
      PT_PLAIN: begin
        // a smooth field: u within +-3, neighbours close to it, v within +-2
        u     = near('0, 3 << 24);
        v     = near('0, 2 << 24);
        p.u   = u;
        p.xp  = near(u, 1 << 21);
        p.xm  = near(u, 1 << 21);
        p.yp  = near(u, 1 << 21);
        p.ym  = near(u, 1 << 21);
        p.zp  = near(u, 1 << 21);
        p.zm  = near(u, 1 << 21);
        p.v   = v;
        p.us  = near(u, 1 << 20);
        p.vs  = near(v, 1 << 20);
        p.sku = near('0, 8 << 24);
        p.skv = near('0, 8 << 24);
      end
      PT_WILD: p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      default: p = {edge_value(), edge_value(), edge_value(), edge_value(),
                    edge_value(), edge_value(), edge_value(), edge_value(),
                    edge_value(), edge_value(), edge_value(), edge_value()};
    endcase
    return p;
  endfunction

  function automatic point_kind_t random_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 72) return PT_PLAIN;
    if (r < 87) return PT_WILD;
    return PT_EDGE;
  endfunction

  task automatic put_point(input point_in_t p);
    u_center  <= p.u;
    u_x_plus  <= p.xp;
    u_x_minus <= p.xm;
    u_y_plus  <= p.yp;
    u_y_minus <= p.ym;
    u_z_plus  <= p.zp;
    u_z_minus <= p.zm;
    v_center  <= p.v;
    u_start   <= p.us;
    v_start   <= p.vs;
    sum_ku    <= p.sku;
    sum_kv    <= p.skv;
  endtask

  // Presents a point and holds it until the transfer; valid is left high.
  task automatic send_point(input point_in_t p);
    put_point(p);
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall !== 1'b0);
    points_sent++;
  endtask

  // Bursts of random length with random gaps; steady phases never drop valid.
  task automatic run_points(input int count, input bit steady);
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_point(make_point(random_kind()));
      left -= burst;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0 && left > 0) begin
        point_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every point has come back.
  task automatic settle();
    point_valid <= 1'b0;
    while (results_seen < points_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all eight registers, one per clock; only called with the pipe empty.
  task automatic load_settings(input coeff_kind_t kind, input logic rk, input logic [1:0] st);
    logic [31:0] vals [8];
    case (kind)
      CF_HIGH: begin
        vals[REG_TIME_STEP]     = 32'h7FFF_FFFF;
        vals[REG_EPS_VALUE]     = 32'h7FFF_FFFF;
        vals[REG_INV_EPS]       = 32'h7FFF_FFFF;
        vals[REG_BETA_VALUE]    = WORD_MAX;
        vals[REG_GAMMA_VALUE]   = WORD_MAX;
        vals[REG_INV_H_SQUARED] = 32'h7FFF_FFFF;
      end
      CF_LOW: begin
        vals[REG_TIME_STEP]     = '0;
        vals[REG_EPS_VALUE]     = '0;
        vals[REG_INV_EPS]       = '0;
        vals[REG_BETA_VALUE]    = WORD_MIN;
        vals[REG_GAMMA_VALUE]   = WORD_MIN;
        vals[REG_INV_H_SQUARED] = '0;
      end
      CF_WILD: begin
        vals[REG_TIME_STEP]     = $urandom & 32'h7FFF_FFFF;
        vals[REG_EPS_VALUE]     = $urandom & 32'h7FFF_FFFF;
        vals[REG_INV_EPS]       = $urandom & 32'h7FFF_FFFF;
        vals[REG_BETA_VALUE]    = $urandom;
        vals[REG_GAMMA_VALUE]   = $urandom;
        vals[REG_INV_H_SQUARED] = $urandom & 32'h7FFF_FFFF;
      end
      default: begin
        // physically sensible: dt up to 0.2, eps up to 1, 1/eps up to 16, 1/h^2 up to 4
        vals[REG_TIME_STEP]     = $urandom_range(0, 3355443);
        vals[REG_EPS_VALUE]     = $urandom_range(0, 1 << 24);
        vals[REG_INV_EPS]       = $urandom_range(0, 1 << 28);
        vals[REG_BETA_VALUE]    = near('0, 2 << 24);
        vals[REG_GAMMA_VALUE]   = near('0, 2 << 24);
        vals[REG_INV_H_SQUARED] = $urandom_range(0, 1 << 26);
      end
    endcase
    vals[REG_USE_RK4]  = {31'b0, rk};
    vals[REG_RK_STAGE] = {30'b0, st};
    for (int i = 0; i < 8; i++) begin
      write_enable <= 1'b1;
      reg_index    <= reg_idx_t'(i);
      write_data   <= vals[i];
      @(posedge clk);
    end
    write_enable <= 1'b0;
  endtask

  initial begin
    coeff_kind_t kind;
    logic        rk;
    logic [1:0]  st;
    rst          <= 1'b1;
    write_enable <= 1'b0;
    reg_index    <= REG_TIME_STEP;
    write_data   <= '0;
    point_valid  <= 1'b0;
    put_point('0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset coefficients (RK4 stage 0), field extremes and a smooth field.
    send_point(make_point(PT_ZERO));
    send_point(make_point(PT_TOP));
    send_point(make_point(PT_BOTTOM));
    send_point(make_point(PT_SPLIT));
    send_point(make_point(PT_PLAIN));
    send_point(make_point(PT_PLAIN));
    settle();

    // Directed: remaining RK4 stages, then Euler with a stale stage left set.
    for (int s = 1; s <= 4; s++) begin
      load_settings(CF_TYPICAL, s != 4, (s == 4) ? RK_STAGE_3 : s[1:0]);
      send_point(make_point(PT_PLAIN));
      send_point(make_point(PT_TOP));
      send_point(make_point(PT_BOTTOM));
      send_point(make_point(PT_EDGE));
      settle();
    end

    // Random phases: every fifth phase is Euler, the rest walk the RK4 stages;
    // a few phases pin the coefficients at their extremes.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0, 23:   kind = CF_HIGH;
        1, 17:   kind = CF_LOW;
        default: kind = (ph % 5 == 3) ? CF_WILD : CF_TYPICAL;
      endcase
      rk = (ph % 5 != 4);
      st = ph[1:0];
      load_settings(kind, rk, st);
      run_points(PHASE_ITEMS, ph % 4 == 1);
      settle();
    end

    // Room for any stray result to surface before the verdict.
    repeat (2 * N_STAGES) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
